FILE: hdl/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types, field widths and codes for the interval set coalescer.
// ----------------------------------------------------------------------------
package isc_pkg;

	// field widths
	localparam int COORD_W         = 16;
	localparam int MODE_W          = 2;
	localparam int STATUS_W        = 2;
	localparam int KIND_W          = 2;
	localparam int TOTAL_W         = 5;
	localparam int S_TDATA_W       = 32;
	localparam int M_TDATA_W       = 48;
	localparam int USER_W          = 2;

	// table sizing
	localparam int DEF_TABLE_DEPTH = 16;
	localparam int MAX_RESULTS     = 32;
	localparam int LIST_W          = 6;

	// request modes
	localparam logic [MODE_W-1:0] MODE_ADD_POINT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD_SEG   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LIST      = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_ADDED    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ABSORBED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd3;

	// listed entry kinds
	localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POINT   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SEGMENT = 2'd2;

	// operands of the shared compare unit
	typedef struct packed {
		logic signed [COORD_W-1:0] x_lo;
		logic signed [COORD_W-1:0] x_hi;
		logic signed [COORD_W-1:0] b;
		logic signed [COORD_W-1:0] e;
	} cmp_req_t;

	// compare flags returned by the shared unit
	typedef struct packed {
		logic b_le_lo;
		logic lo_le_e;
		logic b_le_hi;
		logic hi_le_e;
		logic lo_le_b;
		logic lo_le_hi;
	} cmp_res_t;

	// one result item
	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic [KIND_W-1:0]         kind;
		logic signed [COORD_W-1:0] lo;
		logic signed [COORD_W-1:0] hi;
		logic [TOTAL_W-1:0]        point_total;
		logic [TOTAL_W-1:0]        segment_total;
		logic                      last;
	} res_t;

endpackage

FILE: hdl/isc_cmp.sv
// ----------------------------------------------------------------------------
// isc_cmp
// Shared signed compare unit: one query range against one stored entry.
// ----------------------------------------------------------------------------
module isc_cmp (
	input  isc_pkg::cmp_req_t req,
	output isc_pkg::cmp_res_t res
);
	import isc_pkg::*;

	// all orderings the sequencer needs, from one set of comparators
	always_comb begin
		res.b_le_lo  = (req.b <= req.x_lo);
		res.lo_le_e  = (req.x_lo <= req.e);
		res.b_le_hi  = (req.b <= req.x_hi);
		res.hi_le_e  = (req.x_hi <= req.e);
		res.lo_le_b  = (req.x_lo <= req.b);
		res.lo_le_hi = (req.x_lo <= req.x_hi);
	end

endmodule

FILE: hdl/isc_ctrl.sv
// ----------------------------------------------------------------------------
// isc_ctrl
// Sequencer and entry stores: scans the point and segment tables one entry
// per cycle through the shared compare unit, compacts them, lists them.
// ----------------------------------------------------------------------------
module isc_ctrl #(
	parameter int TABLE_DEPTH = isc_pkg::DEF_TABLE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [isc_pkg::MODE_W-1:0]          in_mode,
	input  logic signed [isc_pkg::COORD_W-1:0]  in_lo,
	input  logic signed [isc_pkg::COORD_W-1:0]  in_hi,
	output isc_pkg::cmp_req_t                   cmp_req,
	input  isc_pkg::cmp_res_t                   cmp_res,
	output logic                                res_valid,
	input  logic                                res_ready,
	output isc_pkg::res_t                       res
);
	import isc_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int TOT_W = (CNT_W + 1 > LIST_W + 1) ? CNT_W + 1 : LIST_W + 1;
	localparam int SEG_W = 2 * COORD_W;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_PFIND   = 9'b000000010,
		S_SFIND   = 9'b000000100,
		S_SCHECK  = 9'b000001000,
		S_SMERGE  = 9'b000010000,
		S_PREMOVE = 9'b000100000,
		S_LPTS    = 9'b001000000,
		S_LSEGS   = 9'b010000000,
		S_RESULT  = 9'b100000000
	} state_t;

	state_t                    state_q, state_d;
	logic [CNT_W-1:0]          i_q, i_d;
	logic [CNT_W-1:0]          np_q, np_d;
	logic [CNT_W-1:0]          ns_q, ns_d;
	logic [LIST_W-1:0]         k_q, k_d;
	logic [LIST_W-1:0]         lt_q, lt_d;
	logic [STATUS_W-1:0]       st_q, st_d;
	logic signed [COORD_W-1:0] a_lo_q, a_lo_d, a_hi_q, a_hi_d;
	logic signed [COORD_W-1:0] m_lo_q, m_lo_d, m_hi_q, m_hi_d;

	// entry stores, read addresses follow the next index so data matches i_q
	logic signed [COORD_W-1:0] pmem [TABLE_DEPTH];
	logic [SEG_W-1:0]          smem [TABLE_DEPTH];
	logic signed [COORD_W-1:0] p_rd_q, p_rd2_q;
	logic [SEG_W-1:0]          s_rd_q, s_rd2_q;
	logic                      p_we, s_we;
	logic [IDX_W-1:0]          p_waddr, s_waddr;
	logic signed [COORD_W-1:0] p_wdata;
	logic [SEG_W-1:0]          s_wdata;
	logic [IDX_W-1:0]          rd_addr, p_rd2_addr, s_rd2_addr;
	logic [CNT_W-1:0]          np_last, ns_last;

	logic [TOT_W-1:0]          tot;
	logic [LIST_W-1:0]         tot_cap;
	logic                      list_last;
	logic                      has_lo, has_hi, inner;
	logic signed [COORD_W-1:0] seg_b, seg_e;

	// read addresses for the next cycle
	assign np_last    = np_d - CNT_W'(1);
	assign ns_last    = ns_d - CNT_W'(1);
	assign rd_addr    = i_d[IDX_W-1:0];
	assign p_rd2_addr = np_last[IDX_W-1:0];
	assign s_rd2_addr = ns_last[IDX_W-1:0];

	// store ports with write-to-read forwarding
	always_ff @(posedge clk) begin
		if (p_we) begin
			pmem[p_waddr] <= p_wdata;
		end
		if (s_we) begin
			smem[s_waddr] <= s_wdata;
		end
		p_rd_q  <= (p_we && p_waddr == rd_addr) ? p_wdata : pmem[rd_addr];
		p_rd2_q <= (p_we && p_waddr == p_rd2_addr) ? p_wdata : pmem[p_rd2_addr];
		s_rd_q  <= (s_we && s_waddr == rd_addr) ? s_wdata : smem[rd_addr];
		s_rd2_q <= (s_we && s_waddr == s_rd2_addr) ? s_wdata : smem[s_rd2_addr];
	end

	// list length, capped
	assign tot     = TOT_W'(np_q) + TOT_W'(ns_q);
	assign tot_cap = (tot > TOT_W'(MAX_RESULTS)) ? LIST_W'(MAX_RESULTS) : LIST_W'(tot);
	assign list_last = (k_q + LIST_W'(1) == lt_q);

	// segment entry halves and merge tests
	assign seg_b  = $signed(s_rd_q[COORD_W-1:0]);
	assign seg_e  = $signed(s_rd_q[SEG_W-1:COORD_W]);
	assign has_lo = cmp_res.b_le_lo && cmp_res.lo_le_e;
	assign has_hi = cmp_res.b_le_hi && cmp_res.hi_le_e;
	assign inner  = cmp_res.lo_le_b && cmp_res.b_le_hi;

	assign in_ready = (state_q == S_IDLE);

	// sequencer
	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		np_d    = np_q;
		ns_d    = ns_q;
		k_d     = k_q;
		lt_d    = lt_q;
		st_d    = st_q;
		a_lo_d  = a_lo_q;
		a_hi_d  = a_hi_q;
		m_lo_d  = m_lo_q;
		m_hi_d  = m_hi_q;
		p_we    = 1'b0;
		p_waddr = i_q[IDX_W-1:0];
		p_wdata = p_rd2_q;
		s_we    = 1'b0;
		s_waddr = i_q[IDX_W-1:0];
		s_wdata = s_rd2_q;

		cmp_req.x_lo = m_lo_q;
		cmp_req.x_hi = m_hi_q;
		cmp_req.b    = p_rd_q;
		cmp_req.e    = p_rd_q;

		res_valid         = 1'b0;
		res.status        = st_q;
		res.kind          = KIND_NONE;
		res.lo            = '0;
		res.hi            = '0;
		res.point_total   = TOTAL_W'(np_q);
		res.segment_total = TOTAL_W'(ns_q);
		res.last          = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					a_lo_d = in_lo;
					a_hi_d = in_hi;
					m_lo_d = in_lo;
					m_hi_d = in_hi;
					i_d    = '0;
					k_d    = '0;
					unique case (in_mode)
						MODE_ADD_POINT: state_d = S_PFIND;
						MODE_ADD_SEG:   state_d = S_SCHECK;
						MODE_LIST: begin
							if (tot == '0) begin
								st_d    = STATUS_ABSORBED;
								state_d = S_RESULT;
							end else begin
								lt_d    = tot_cap;
								state_d = (np_q != '0) ? S_LPTS : S_LSEGS;
							end
						end
						default: begin
							st_d    = STATUS_ABSORBED;
							state_d = S_RESULT;
						end
					endcase
				end
			end

			// add point: look for an equal point
			S_PFIND: begin
				if (i_q == np_q) begin
					i_d     = '0;
					state_d = S_SFIND;
				end else if (cmp_res.b_le_lo && cmp_res.lo_le_e) begin
					st_d    = STATUS_ABSORBED;
					state_d = S_RESULT;
				end else begin
					i_d = i_q + CNT_W'(1);
				end
			end

			// add point: look for a covering segment, then store
			S_SFIND: begin
				cmp_req.b = seg_b;
				cmp_req.e = seg_e;
				if (i_q == ns_q) begin
					if (np_q >= CNT_W'(TABLE_DEPTH)) begin
						st_d = STATUS_FULL;
					end else begin
						p_we    = 1'b1;
						p_waddr = np_q[IDX_W-1:0];
						p_wdata = a_lo_q;
						np_d    = np_q + CNT_W'(1);
						st_d    = STATUS_ADDED;
					end
					state_d = S_RESULT;
				end else if (has_lo) begin
					st_d    = STATUS_ABSORBED;
					state_d = S_RESULT;
				end else begin
					i_d = i_q + CNT_W'(1);
				end
			end

			// add segment: reject reversed bounds
			S_SCHECK: begin
				cmp_req.x_lo = a_lo_q;
				cmp_req.x_hi = a_hi_q;
				if (!cmp_res.lo_le_hi) begin
					st_d    = STATUS_INVALID;
					state_d = S_RESULT;
				end else begin
					state_d = S_SMERGE;
				end
			end

			// add segment: absorb overlapping or touching segments
			S_SMERGE: begin
				cmp_req.b = seg_b;
				cmp_req.e = seg_e;
				if (i_q == ns_q) begin
					if (ns_q >= CNT_W'(TABLE_DEPTH)) begin
						st_d    = STATUS_FULL;
						state_d = S_RESULT;
					end else begin
						s_we    = 1'b1;
						s_waddr = ns_q[IDX_W-1:0];
						s_wdata = {m_hi_q, m_lo_q};
						ns_d    = ns_q + CNT_W'(1);
						i_d     = '0;
						state_d = S_PREMOVE;
					end
				end else if (has_lo && has_hi) begin
					st_d    = STATUS_ABSORBED;
					state_d = S_RESULT;
				end else if (has_lo || has_hi || inner) begin
					if (has_lo) begin
						m_lo_d = seg_b;
					end else if (has_hi) begin
						m_hi_d = seg_e;
					end
					// last entry moves into the freed slot
					s_we = 1'b1;
					ns_d = ns_q - CNT_W'(1);
				end else begin
					i_d = i_q + CNT_W'(1);
				end
			end

			// add segment: drop points under the new segment
			S_PREMOVE: begin
				cmp_req.x_lo = a_lo_q;
				cmp_req.x_hi = a_hi_q;
				if (i_q == np_q) begin
					st_d    = STATUS_ADDED;
					state_d = S_RESULT;
				end else if (cmp_res.lo_le_b && cmp_res.b_le_hi) begin
					p_we = 1'b1;
					np_d = np_q - CNT_W'(1);
				end else begin
					i_d = i_q + CNT_W'(1);
				end
			end

			// list points
			S_LPTS: begin
				res_valid  = 1'b1;
				res.status = STATUS_ABSORBED;
				res.kind   = KIND_POINT;
				res.lo     = p_rd_q;
				res.hi     = p_rd_q;
				res.last   = list_last;
				if (res_ready) begin
					k_d = k_q + LIST_W'(1);
					if (list_last) begin
						state_d = S_IDLE;
					end else if (i_q + CNT_W'(1) == np_q) begin
						i_d     = '0;
						state_d = S_LSEGS;
					end else begin
						i_d = i_q + CNT_W'(1);
					end
				end
			end

			// list segments
			S_LSEGS: begin
				res_valid  = 1'b1;
				res.status = STATUS_ABSORBED;
				res.kind   = KIND_SEGMENT;
				res.lo     = seg_b;
				res.hi     = seg_e;
				res.last   = list_last;
				if (res_ready) begin
					k_d = k_q + LIST_W'(1);
					if (list_last) begin
						state_d = S_IDLE;
					end else begin
						i_d = i_q + CNT_W'(1);
					end
				end
			end

			// single status result
			S_RESULT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			np_q    <= '0;
			ns_q    <= '0;
			k_q     <= '0;
			lt_q    <= '0;
			st_q    <= STATUS_ADDED;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			np_q    <= np_d;
			ns_q    <= ns_d;
			k_q     <= k_d;
			lt_q    <= lt_d;
			st_q    <= st_d;
		end
	end

	// request operands
	always_ff @(posedge clk) begin
		a_lo_q <= a_lo_d;
		a_hi_q <= a_hi_d;
		m_lo_q <= m_lo_d;
		m_hi_q <= m_hi_d;
	end

endmodule

FILE: hdl/interval_set_coalescer.sv
// ----------------------------------------------------------------------------
// interval_set_coalescer
// Set of isolated points and disjoint closed segments on a signed axis.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: s_tuser carries the mode (add point,
// add segment, list), s_tdata the start and end coordinates. Each add gives
// one result transfer on the m_ stream with a status and the new table
// totals; a list gives one transfer per stored entry (points first, then
// segments, at most 32; one status transfer if both tables are empty),
// m_tuser holding the entry kind and m_tlast marking the final transfer
// of the request. An add point scans the point table and then the segment
// table, an add segment the segment table and then the point table, one
// entry per cycle through the single compare unit. One request is worked
// at a time; s_tready is high only while the sequencer is idle.
// Reset empties both tables at once (the stores themselves are not cleared,
// only the counts). When m_tready is low the result waits in the output
// register and the sequencer holds its next result until that one leaves.
// ----------------------------------------------------------------------------
module interval_set_coalescer #(
	parameter int TABLE_DEPTH = isc_pkg::DEF_TABLE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [isc_pkg::S_TDATA_W-1:0]   s_tdata,  // coord_lo, coord_hi
	input  logic [isc_pkg::USER_W-1:0]      s_tuser,  // mode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// status, entry_lo, entry_hi, point_total, segment_total, zero pad
	output logic [isc_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [isc_pkg::USER_W-1:0]      m_tuser,  // entry_kind
	output logic                            m_tlast
);
	import isc_pkg::*;

	localparam int PAD_W = M_TDATA_W - STATUS_W - 2 * COORD_W - 2 * TOTAL_W;

	cmp_req_t cmp_req;
	cmp_res_t cmp_res;
	res_t     res;
	logic     res_valid, res_ready;
	res_t     out_q;
	logic     out_valid_q;

	// shared compare unit
	isc_cmp u_cmp (
		.req (cmp_req),
		.res (cmp_res)
	);

	// sequencer and stores
	isc_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser[MODE_W-1:0]),
		.in_lo     ($signed(s_tdata[COORD_W-1:0])),
		.in_hi     ($signed(s_tdata[2*COORD_W-1:COORD_W])),
		.cmp_req   (cmp_req),
		.cmp_res   (cmp_res),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register, refilled as it drains
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	// master-side packing
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_q.segment_total, out_q.point_total,
		out_q.hi, out_q.lo, out_q.status};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;

endmodule

FILE: hdl/isc_checker.sv
// ----------------------------------------------------------------------------
// isc_checker
// Port-level checks for the interval set coalescer, bound to the top level.
// ----------------------------------------------------------------------------
module isc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [isc_pkg::M_TDATA_W-1:0]   m_tdata,
	input logic [isc_pkg::USER_W-1:0]      m_tuser,
	input logic                            m_tlast
);
	import isc_pkg::*;

	// a stalled result transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// status-only results stand alone
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_NONE |-> m_tlast)
		else $error("status result not marked last");

	// listed points report equal ends
	a_point_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_POINT |->
			m_tdata[STATUS_W+COORD_W-1:STATUS_W]
				== m_tdata[STATUS_W+2*COORD_W-1:STATUS_W+COORD_W])
		else $error("listed point with differing ends");

	// listed segments are ordered
	a_seg_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_SEGMENT |->
			$signed(m_tdata[STATUS_W+COORD_W-1:STATUS_W])
				<= $signed(m_tdata[STATUS_W+2*COORD_W-1:STATUS_W+COORD_W]))
		else $error("listed segment with start above end");

endmodule

bind interval_set_coalescer isc_checker u_isc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
